// ===== design/assert_macros.svh =====
// assertion macros used by the scc datapath
// no dependencies; expands to nothing when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property must hold at every clock edge out of reset
`define SCC_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// condition must never be seen out of reset
`define SCC_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define SCC_ASSERT(lbl, clk, rst_n, prop, msg)
`define SCC_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

// ===== design/scc_pkg.sv =====
// shared types and constants for the strongly connected components block
// no dependencies
`timescale 1ns / 1ps
package scc_pkg;

  localparam int VERTEX_W = 6;
  localparam int CFG_W    = 7;
  localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

  // input beat
  typedef struct packed {
    logic                kind;
    logic [VERTEX_W-1:0] source;
    logic [VERTEX_W-1:0] target;
    logic                present;
  } scc_in_t;

  // result beat
  typedef struct packed {
    logic [VERTEX_W-1:0] vertex;
    logic [VERTEX_W-1:0] component;
    logic                component_end;
    logic                last;
  } scc_out_t;

  // datapath commands
  typedef enum logic [3:0] {
    OP_NONE,
    OP_CAPTURE,
    OP_EDGE_RD,
    OP_EDGE_WB,
    OP_P1_INIT,
    OP_P2_INIT,
    OP_X_INC,
    OP_WALK_START,
    OP_Y_INC,
    OP_PUSH,
    OP_FINISH_POP,
    OP_FINISH_END,
    OP_POP_LOAD,
    OP_FO_RD,
    OP_FLUSH
  } scc_op_t;

  // controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_EDGE_RD,
    ST_EDGE_WB,
    ST_P1_INIT,
    ST_P1_PICK,
    ST_SCAN,
    ST_POP,
    ST_P2_INIT,
    ST_P2_RD,
    ST_P2_PICK,
    ST_DONE
  } scc_state_t;

  // datapath status to controller
  typedef struct packed {
    logic kind;
    logic edge_ok;
    logic x_end;
    logic x_seen;
    logic y_end;
    logic y_fresh;
    logic depth_zero;
    logic s_skip;
    logic pass2;
  } scc_status_t;

endpackage

// ===== design/scc_dpath.sv =====
// datapath: adjacency memories, walk stack, finish order and result beats
// depends on scc_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"
module scc_dpath import scc_pkg::*; #(
  parameter int MAX_VERTICES = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  scc_in_t           in_item,
  input  scc_op_t           op,
  output scc_status_t       status,
  input  logic              cfg_valid,
  input  logic [CFG_W-1:0]  cfg_data,
  output logic              cfg_ready,
  output logic              out_valid,
  output scc_out_t          out_item
);

  localparam int VW = $clog2(MAX_VERTICES);
  localparam int CW = $clog2(MAX_VERTICES + 1);

  typedef struct packed {
    logic [VW-1:0] v;
    logic [CW-1:0] y;
  } stk_t;

  // memories
  logic [MAX_VERTICES-1:0] fwd_mem [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] rev_mem [MAX_VERTICES];
  stk_t                    stack_mem [MAX_VERTICES];
  logic [VW-1:0]           fo_mem [MAX_VERTICES];

  logic [MAX_VERTICES-1:0] fvalid_r, rvalid_r;
  logic [MAX_VERTICES-1:0] fwd_q_r, rev_q_r;
  stk_t                    stack_q_r;
  logic [VW-1:0]           fo_q_r;

  logic [CFG_W-1:0]        vcount_r;
  scc_in_t                 item_r;
  logic                    pass2_r;
  logic [MAX_VERTICES-1:0] visited_r;
  logic [CW-1:0]           x_r, k_r, cur_y_r, depth_r;
  logic [VW-1:0]           cur_v_r, comp_r;
  logic                    pend_valid_r, out_valid_r;
  scc_out_t                pend_r, out_item_r;

  logic [CW-1:0]           n;
  logic [VW-1:0]           src_v, tgt_v, start_v, y_idx, f_addr, r_addr, fo_addr;
  logic [MAX_VERTICES-1:0] row, fwd_new, rev_new;
  logic                    row_rd, emit, newcomp, fin;
  logic [VW-1:0]           emit_v;

  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // vertices in use, clipped to the maximum
  always_comb begin
    if (vcount_r > CFG_W'(MAX_VERTICES)) begin
      n = CW'(MAX_VERTICES);
    end else begin
      n = CW'(vcount_r);
    end
  end

  assign src_v   = item_r.source[VW-1:0];
  assign tgt_v   = item_r.target[VW-1:0];
  assign start_v = pass2_r ? fo_q_r : x_r[VW-1:0];
  assign y_idx   = cur_y_r[VW-1:0];
  assign row     = pass2_r ? rev_q_r : fwd_q_r;
  assign fo_addr = VW'(n - CW'(1) - x_r);

  // status to controller
  always_comb begin
    status.kind       = item_r.kind;
    status.edge_ok    = ({1'b0, item_r.source} < CFG_W'(MAX_VERTICES)) &&
                        ({1'b0, item_r.target} < CFG_W'(MAX_VERTICES));
    status.x_end      = x_r >= n;
    status.x_seen     = visited_r[x_r[VW-1:0]];
    status.y_end      = cur_y_r >= n;
    status.y_fresh    = row[y_idx] & ~visited_r[y_idx];
    status.depth_zero = depth_r == '0;
    status.s_skip     = (CW'(fo_q_r) >= n) || visited_r[fo_q_r];
    status.pass2      = pass2_r;
  end

  // row read address
  always_comb begin
    row_rd = 1'b0;
    f_addr = src_v;
    r_addr = tgt_v;
    case (op)
      OP_EDGE_RD: begin
        row_rd = 1'b1;
      end
      OP_WALK_START: begin
        row_rd = 1'b1;
        f_addr = start_v;
        r_addr = start_v;
      end
      OP_PUSH: begin
        row_rd = 1'b1;
        f_addr = y_idx;
        r_addr = y_idx;
      end
      OP_POP_LOAD: begin
        row_rd = 1'b1;
        f_addr = stack_q_r.v;
        r_addr = stack_q_r.v;
      end
      default: begin
        row_rd = 1'b0;
      end
    endcase
  end

  // modified rows for an edge write
  always_comb begin
    fwd_new        = fwd_q_r;
    rev_new        = rev_q_r;
    fwd_new[tgt_v] = item_r.present;
    rev_new[src_v] = item_r.present;
  end

  // adjacency memories, rows never written read as zero
  always_ff @(posedge clk) begin
    if (row_rd) begin
      fwd_q_r <= fvalid_r[f_addr] ? fwd_mem[f_addr] : '0;
      rev_q_r <= rvalid_r[r_addr] ? rev_mem[r_addr] : '0;
    end
    if (op == OP_EDGE_WB) begin
      fwd_mem[src_v] <= fwd_new;
      rev_mem[tgt_v] <= rev_new;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fvalid_r <= '0;
      rvalid_r <= '0;
    end else if (op == OP_EDGE_WB) begin
      fvalid_r[src_v] <= 1'b1;
      rvalid_r[tgt_v] <= 1'b1;
    end
  end

  // walk stack and finish order memories
  assign fin = (op == OP_FINISH_POP) || (op == OP_FINISH_END);

  always_ff @(posedge clk) begin
    if (op == OP_PUSH) begin
      stack_mem[depth_r[VW-1:0]] <= '{v: cur_v_r, y: cur_y_r + CW'(1)};
    end
    if (op == OP_FINISH_POP) begin
      stack_q_r <= stack_mem[VW'(depth_r - CW'(1))];
    end
    if (fin && !pass2_r) begin
      fo_mem[k_r[VW-1:0]] <= cur_v_r;
    end
    if (op == OP_FO_RD) begin
      fo_q_r <= fo_mem[fo_addr];
    end
  end

  // emission in the second pass
  assign emit    = pass2_r && ((op == OP_WALK_START) || (op == OP_PUSH));
  assign newcomp = op == OP_WALK_START;
  assign emit_v  = newcomp ? start_v : y_idx;

  // walk control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcount_r     <= CFG_RESET;
      pass2_r      <= 1'b0;
      visited_r    <= '0;
      x_r          <= '0;
      k_r          <= '0;
      cur_y_r      <= '0;
      cur_v_r      <= '0;
      depth_r      <= '0;
      comp_r       <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_valid) begin
        vcount_r <= cfg_data;
      end
      out_valid_r <= (emit || (op == OP_FLUSH)) && pend_valid_r;
      if (emit) begin
        pend_valid_r <= 1'b1;
      end
      case (op)
        OP_P1_INIT: begin
          visited_r <= '0;
          x_r       <= '0;
          k_r       <= '0;
          pass2_r   <= 1'b0;
        end
        OP_P2_INIT: begin
          visited_r    <= '0;
          x_r          <= '0;
          comp_r       <= '0;
          pass2_r      <= 1'b1;
          pend_valid_r <= 1'b0;
        end
        OP_X_INC: begin
          x_r <= x_r + CW'(1);
        end
        OP_WALK_START: begin
          visited_r[start_v] <= 1'b1;
          cur_v_r            <= start_v;
          cur_y_r            <= '0;
          depth_r            <= '0;
        end
        OP_Y_INC: begin
          cur_y_r <= cur_y_r + CW'(1);
        end
        OP_PUSH: begin
          depth_r          <= depth_r + CW'(1);
          visited_r[y_idx] <= 1'b1;
          cur_v_r          <= y_idx;
          cur_y_r          <= '0;
        end
        OP_FINISH_POP: begin
          if (!pass2_r) begin
            k_r <= k_r + CW'(1);
          end
          depth_r <= depth_r - CW'(1);
        end
        OP_FINISH_END: begin
          if (!pass2_r) begin
            k_r <= k_r + CW'(1);
          end else begin
            comp_r <= comp_r + VW'(1);
          end
          x_r <= x_r + CW'(1);
        end
        OP_POP_LOAD: begin
          cur_v_r <= stack_q_r.v;
          cur_y_r <= stack_q_r.y;
        end
        OP_FLUSH: begin
          pend_valid_r <= 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (op == OP_CAPTURE) begin
      item_r <= in_item;
    end
    if (emit) begin
      pend_r.vertex        <= VERTEX_W'(emit_v);
      pend_r.component     <= VERTEX_W'(comp_r);
      pend_r.component_end <= 1'b0;
      pend_r.last          <= 1'b0;
      out_item_r.vertex        <= pend_r.vertex;
      out_item_r.component     <= pend_r.component;
      out_item_r.component_end <= newcomp;
      out_item_r.last          <= 1'b0;
    end else if (op == OP_FLUSH) begin
      out_item_r.vertex        <= pend_r.vertex;
      out_item_r.component     <= pend_r.component;
      out_item_r.component_end <= 1'b1;
      out_item_r.last          <= 1'b1;
    end
  end

  // checks
  `SCC_NEVER(a_push_fresh, clk, rst_n, (op == OP_PUSH) && visited_r[y_idx], "push of a visited vertex")
  `SCC_ASSERT(a_depth_bound, clk, rst_n, depth_r < n || depth_r == '0, "stack depth beyond vertex count")
  `SCC_ASSERT(a_out_cause, clk, rst_n, out_valid_r |-> $past(emit || (op == OP_FLUSH)), "result beat without cause")
  `SCC_ASSERT(a_flush_clear, clk, rst_n, (op == OP_FLUSH) |=> !pend_valid_r, "pending beat kept after flush")

endmodule

// ===== design/scc_ctrl.sv =====
// controller state machine sequencing edge writes and both walks
// depends on scc_pkg
`timescale 1ns / 1ps
module scc_ctrl import scc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  scc_status_t status,
  output scc_op_t     op,
  output logic        busy
);

  scc_state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = state_r != ST_IDLE;

  // next state and command
  always_comb begin
    state_nxt = state_r;
    op        = OP_NONE;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          op        = OP_CAPTURE;
          state_nxt = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (status.kind) begin
          state_nxt = ST_P1_INIT;
        end else if (status.edge_ok) begin
          state_nxt = ST_EDGE_RD;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_EDGE_RD: begin
        op        = OP_EDGE_RD;
        state_nxt = ST_EDGE_WB;
      end
      ST_EDGE_WB: begin
        op        = OP_EDGE_WB;
        state_nxt = ST_IDLE;
      end
      ST_P1_INIT: begin
        op        = OP_P1_INIT;
        state_nxt = ST_P1_PICK;
      end
      ST_P1_PICK: begin
        if (status.x_end) begin
          state_nxt = ST_P2_INIT;
        end else if (status.x_seen) begin
          op = OP_X_INC;
        end else begin
          op        = OP_WALK_START;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (status.y_end) begin
          if (status.depth_zero) begin
            op        = OP_FINISH_END;
            state_nxt = status.pass2 ? ST_P2_RD : ST_P1_PICK;
          end else begin
            op        = OP_FINISH_POP;
            state_nxt = ST_POP;
          end
        end else if (status.y_fresh) begin
          op = OP_PUSH;
        end else begin
          op = OP_Y_INC;
        end
      end
      ST_POP: begin
        op        = OP_POP_LOAD;
        state_nxt = ST_SCAN;
      end
      ST_P2_INIT: begin
        op        = OP_P2_INIT;
        state_nxt = ST_P2_RD;
      end
      ST_P2_RD: begin
        if (status.x_end) begin
          state_nxt = ST_DONE;
        end else begin
          op        = OP_FO_RD;
          state_nxt = ST_P2_PICK;
        end
      end
      ST_P2_PICK: begin
        if (status.s_skip) begin
          op        = OP_X_INC;
          state_nxt = ST_P2_RD;
        end else begin
          op        = OP_WALK_START;
          state_nxt = ST_SCAN;
        end
      end
      ST_DONE: begin
        op        = OP_FLUSH;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== design/strongly_connected_components.sv =====
// top level of the strongly connected components block
// depends on scc_pkg, scc_ctrl and scc_dpath
`timescale 1ns / 1ps
// An edge write is taken when start is high and busy low, and keeps busy high through
// the decode, edge read and edge write-back states; an out-of-range edge returns to idle
// from decode. A run keeps busy high while both depth-first walks go on, one candidate
// neighbour per cycle out of the adjacency row of the current vertex while scanning, with
// push, pop and finish steps between. Results come one per vertex on out_valid for a
// single cycle each and cannot be held off; each beat leaves one vertex behind the walk,
// and the last one appears as the run ends. No clearing pass follows reset.
module strongly_connected_components import scc_pkg::*; #(
  parameter int MAX_VERTICES = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  scc_in_t          in_item,
  output logic             out_valid,
  output scc_out_t         out_item,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CFG_W-1:0] cfg_data
);

  scc_op_t     op;
  scc_status_t status;

  // sequencer
  scc_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .status (status),
    .op     (op),
    .busy   (busy)
  );

  // storage and walk datapath
  scc_dpath #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .op        (op),
    .status    (status),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .cfg_ready (cfg_ready),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule
